[hdl/css_pkg.sv]
// Shared types and constants for the cooler stability sequencer.
`timescale 1ns / 1ps

package css_pkg;

   // Cooler phase codes, as reported on rsp_cooler_state
   typedef enum logic [2:0] {
      PH_OFF         = 3'd0,
      PH_STARTING    = 3'd1,
      PH_COOLING     = 3'd2,
      PH_STABILIZING = 3'd3,
      PH_STABLE      = 3'd4,
      PH_STOPPING    = 3'd5,
      PH_ERROR       = 3'd6
   } phase_type;

   // Request command codes
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_SET   = 2'd3
   } mode_type;

   // Stability event codes
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_STABLE = 2'd1,
      EV_LEFT   = 2'd2
   } event_type;

   // Control state that moves between the step logic and the top level
   typedef struct packed {
      phase_type phase;
      logic      cooler_on;
      logic      monitor_on;
   } ctrl_type;

   // CSR map
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE_TICKS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROTECT_EN   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEMP_CEILING = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEMP_FLOOR   = 3'd4;

   // Register widths fixed by the CSR map
   localparam int TOL_BITS    = 15;
   localparam int SETTLE_BITS = 16;

   // Reset values: 0.5 deg tolerance, 30 ticks, +50 / -50 deg window
   localparam logic [TOL_BITS-1:0]    TOL_RESET    = 15'd128;
   localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 16'd30;
   localparam int                     CEIL_RESET   = 12800;
   localparam int                     FLOOR_RESET  = -12800;

endpackage

[hdl/cooler_stability_sequencer.sv]
// Camera cooler sequencer: state registers, CSRs and the result register.
`timescale 1ns / 1ps

// Cooler stability sequencer. Each request transfer (tick, start, stop or set
// target) is applied to the sequencer state in the cycle it is accepted and
// its result appears on the rsp_ channel the next cycle, one transfer per
// cycle sustained while rsp_stall is low. The single result register is the only
// buffer; req_stall rises only while a finished result is held by rsp_stall,
// and a result being taken in the same cycle frees room for the next request.
// Temperatures are signed, TEMP_BITS wide, in 1/256 degree units; temp_delta
// is one bit wider. The settle counter saturates at its COUNT_BITS maximum.
// CSRs (tolerance, settle_ticks, protect_enable, temp_ceiling, temp_floor at
// indexes 0 to 4) are always ready; write them only while no request is in
// flight. Writes to other indexes are dropped. No clearing pass after reset.
module cooler_stability_sequencer #(
   parameter int TEMP_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic signed [TEMP_BITS-1:0]         req_sample_temp,
   input  logic signed [TEMP_BITS-1:0]         req_new_target,
   input  logic                                req_connected,
   input  logic                                req_enable_ack,
   input  logic                                req_target_ack,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [2:0]                          rsp_cooler_state,
   output logic                                rsp_cooler_enabled,
   output logic                                rsp_monitor_active,
   output logic signed [TEMP_BITS-1:0]         rsp_current_temp,
   output logic signed [TEMP_BITS:0]           rsp_temp_delta,
   output logic [1:0]                          rsp_stability_event,
   // CSR write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [css_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [css_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam logic signed [TEMP_BITS-1:0] CEIL_RST  = TEMP_BITS'(css_pkg::CEIL_RESET);
   localparam logic signed [TEMP_BITS-1:0] FLOOR_RST = TEMP_BITS'(css_pkg::FLOOR_RESET);

   // CSRs
   logic [css_pkg::TOL_BITS-1:0]    tolerance_ff;
   logic [css_pkg::SETTLE_BITS-1:0] settle_ticks_ff;
   logic                            protect_en_ff;
   logic signed [TEMP_BITS-1:0]     temp_ceiling_ff;
   logic signed [TEMP_BITS-1:0]     temp_floor_ff;

   // sequencer state
   css_pkg::ctrl_type               ctrl_ff;
   css_pkg::ctrl_type               ctrl_in;
   logic signed [TEMP_BITS-1:0]     target_ff;
   logic signed [TEMP_BITS-1:0]     target_in;
   logic signed [TEMP_BITS-1:0]     last_ff;
   logic signed [TEMP_BITS-1:0]     last_in;
   logic [COUNT_BITS-1:0]           count_ff;
   logic [COUNT_BITS-1:0]           count_in;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            accepted_ff;
   logic                            accepted_in;
   css_pkg::ctrl_type               rsp_ctrl_ff;
   logic signed [TEMP_BITS:0]       delta_ff;
   logic signed [TEMP_BITS:0]       delta_in;
   css_pkg::event_type              event_ff;
   css_pkg::event_type              event_in;
   logic signed [TEMP_BITS-1:0]     cur_temp_ff;

   logic                            req_xfer;

   // a held result blocks new requests; one taken this cycle makes room
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff    <= css_pkg::TOL_RESET;
         settle_ticks_ff <= css_pkg::SETTLE_RESET;
         protect_en_ff   <= 1'b1;
         temp_ceiling_ff <= CEIL_RST;
         temp_floor_ff   <= FLOOR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            css_pkg::CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[css_pkg::TOL_BITS-1:0];
            css_pkg::CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[css_pkg::SETTLE_BITS-1:0];
            css_pkg::CSR_PROTECT_EN:   protect_en_ff   <= csr_wdata[0];
            css_pkg::CSR_TEMP_CEILING: temp_ceiling_ff <= csr_wdata[TEMP_BITS-1:0];
            css_pkg::CSR_TEMP_FLOOR:   temp_floor_ff   <= csr_wdata[TEMP_BITS-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   css_step #(
      .TEMP_BITS  (TEMP_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .mode           (req_mode),
      .sample_temp    (req_sample_temp),
      .new_target     (req_new_target),
      .connected      (req_connected),
      .enable_ack     (req_enable_ack),
      .target_ack     (req_target_ack),
      .ctrl_cur       (ctrl_ff),
      .target_cur     (target_ff),
      .last_cur       (last_ff),
      .count_cur      (count_ff),
      .tolerance      (tolerance_ff),
      .settle_ticks   (settle_ticks_ff),
      .protect_enable (protect_en_ff),
      .temp_ceiling   (temp_ceiling_ff),
      .temp_floor     (temp_floor_ff),
      .ctrl_nxt       (ctrl_in),
      .target_nxt     (target_in),
      .last_nxt       (last_in),
      .count_nxt      (count_in),
      .accepted       (accepted_in),
      .stab_event     (event_in),
      .temp_delta     (delta_in)
   );

   // state commits only on an accepted request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '{phase: css_pkg::PH_OFF, cooler_on: 1'b0, monitor_on: 1'b0};
         target_ff <= '0;
         last_ff   <= '0;
         count_ff  <= '0;
      end else if (req_xfer) begin
         ctrl_ff   <= ctrl_in;
         target_ff <= target_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with the transfer that produced it
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         accepted_ff <= accepted_in;
         rsp_ctrl_ff <= ctrl_in;
         cur_temp_ff <= last_in;
         delta_ff    <= delta_in;
         event_ff    <= event_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = accepted_ff;
   assign rsp_cooler_state    = rsp_ctrl_ff.phase;
   assign rsp_cooler_enabled  = rsp_ctrl_ff.cooler_on;
   assign rsp_monitor_active  = rsp_ctrl_ff.monitor_on;
   assign rsp_current_temp    = cur_temp_ff;
   assign rsp_temp_delta      = delta_ff;
   assign rsp_stability_event = event_ff;

endmodule

[hdl/css_step.sv]
// Next-state and result logic for one sequencer transfer.
`timescale 1ns / 1ps

module css_step #(
   parameter int TEMP_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic [1:0]                         mode,
   input  logic signed [TEMP_BITS-1:0]        sample_temp,
   input  logic signed [TEMP_BITS-1:0]        new_target,
   input  logic                               connected,
   input  logic                               enable_ack,
   input  logic                               target_ack,
   input  css_pkg::ctrl_type                  ctrl_cur,
   input  logic signed [TEMP_BITS-1:0]        target_cur,
   input  logic signed [TEMP_BITS-1:0]        last_cur,
   input  logic [COUNT_BITS-1:0]              count_cur,
   input  logic [css_pkg::TOL_BITS-1:0]       tolerance,
   input  logic [css_pkg::SETTLE_BITS-1:0]    settle_ticks,
   input  logic                               protect_enable,
   input  logic signed [TEMP_BITS-1:0]        temp_ceiling,
   input  logic signed [TEMP_BITS-1:0]        temp_floor,
   output css_pkg::ctrl_type                  ctrl_nxt,
   output logic signed [TEMP_BITS-1:0]        target_nxt,
   output logic signed [TEMP_BITS-1:0]        last_nxt,
   output logic [COUNT_BITS-1:0]              count_nxt,
   output logic                               accepted,
   output css_pkg::event_type                 stab_event,
   output logic signed [TEMP_BITS:0]          temp_delta
);

   localparam int DEV_BITS = (TEMP_BITS + 1 > css_pkg::TOL_BITS) ?
                             TEMP_BITS + 1 : css_pkg::TOL_BITS;
   localparam int CMP_BITS = (COUNT_BITS > css_pkg::SETTLE_BITS) ?
                             COUNT_BITS : css_pkg::SETTLE_BITS;

   logic signed [TEMP_BITS-1:0] cur_temp;
   logic signed [TEMP_BITS:0]   dev;
   logic [TEMP_BITS:0]          abs_dev;
   logic                        in_tol;
   logic [COUNT_BITS-1:0]       count_inc;
   logic                        settled;
   logic                        trip;
   logic                        target_ok;
   logic                        tracking;

   // stale sample is reused while the link is down
   assign cur_temp  = connected ? sample_temp : last_cur;
   assign dev       = {cur_temp[TEMP_BITS-1], cur_temp} - {target_cur[TEMP_BITS-1], target_cur};
   assign abs_dev   = dev[TEMP_BITS] ? (~dev + 1'b1) : dev;
   assign in_tol    = DEV_BITS'(abs_dev) <= DEV_BITS'(tolerance);
   assign count_inc = (count_cur == '1) ? count_cur : count_cur + 1'b1;
   assign settled   = CMP_BITS'(count_inc) >= CMP_BITS'(settle_ticks);
   assign trip      = protect_enable && (cur_temp > temp_ceiling || cur_temp < temp_floor);
   assign target_ok = !protect_enable ||
                      (new_target >= temp_floor && new_target <= temp_ceiling);
   assign tracking  = ctrl_cur.phase == css_pkg::PH_COOLING ||
                      ctrl_cur.phase == css_pkg::PH_STABILIZING ||
                      ctrl_cur.phase == css_pkg::PH_STABLE;

   always_comb begin
      ctrl_nxt   = ctrl_cur;
      target_nxt = target_cur;
      last_nxt   = last_cur;
      count_nxt  = count_cur;
      accepted   = 1'b1;
      stab_event = css_pkg::EV_NONE;

      unique case (css_pkg::mode_type'(mode))
         css_pkg::MODE_TICK: begin
            if (ctrl_cur.monitor_on) begin
               last_nxt = cur_temp;
               if (tracking) begin
                  if (in_tol) begin
                     if (ctrl_cur.phase == css_pkg::PH_COOLING) begin
                        ctrl_nxt.phase = css_pkg::PH_STABILIZING;
                        count_nxt      = '0;
                     end else if (ctrl_cur.phase == css_pkg::PH_STABILIZING) begin
                        count_nxt = count_inc;
                        if (settled) begin
                           ctrl_nxt.phase = css_pkg::PH_STABLE;
                           stab_event     = css_pkg::EV_STABLE;
                        end
                     end
                  end else if (ctrl_cur.phase != css_pkg::PH_COOLING) begin
                     ctrl_nxt.phase = css_pkg::PH_COOLING;
                     stab_event     = css_pkg::EV_LEFT;
                  end
               end
               if (trip) begin
                  ctrl_nxt.phase     = css_pkg::PH_ERROR;
                  ctrl_nxt.cooler_on = 1'b0;
               end
            end
         end
         css_pkg::MODE_START: begin
            if (!connected || !target_ok) begin
               accepted = 1'b0;
            end else begin
               // any running state is shut down first
               if (ctrl_cur.phase != css_pkg::PH_OFF) begin
                  ctrl_nxt.monitor_on = 1'b0;
                  ctrl_nxt.cooler_on  = 1'b0;
               end
               target_nxt = new_target;
               if (!enable_ack) begin
                  ctrl_nxt.phase = css_pkg::PH_ERROR;
                  accepted       = 1'b0;
               end else begin
                  ctrl_nxt.cooler_on = 1'b1;
                  if (!target_ack) begin
                     ctrl_nxt.phase = css_pkg::PH_ERROR;
                     accepted       = 1'b0;
                  end else begin
                     ctrl_nxt.phase      = css_pkg::PH_COOLING;
                     ctrl_nxt.monitor_on = 1'b1;
                     count_nxt           = '0;
                  end
               end
            end
         end
         css_pkg::MODE_STOP: begin
            if (ctrl_cur.phase != css_pkg::PH_OFF) begin
               ctrl_nxt.phase      = css_pkg::PH_OFF;
               ctrl_nxt.monitor_on = 1'b0;
               // cooler can only be commanded off over a live link
               if (connected) begin
                  ctrl_nxt.cooler_on = 1'b0;
               end
            end
         end
         css_pkg::MODE_SET: begin
            if (!target_ok || !connected) begin
               accepted = 1'b0;
            end else begin
               target_nxt = new_target;
               if (ctrl_cur.phase != css_pkg::PH_OFF &&
                   ctrl_cur.phase != css_pkg::PH_ERROR) begin
                  if (!target_ack) begin
                     accepted = 1'b0;
                  end else begin
                     count_nxt = '0;
                     if (ctrl_cur.phase == css_pkg::PH_STABLE) begin
                        ctrl_nxt.phase = css_pkg::PH_COOLING;
                     end
                  end
               end
            end
         end
         default: begin
            accepted = 1'b1;
         end
      endcase
   end

   assign temp_delta = {last_nxt[TEMP_BITS-1], last_nxt} - {target_nxt[TEMP_BITS-1], target_nxt};

endmodule

[hdl/css_checker.sv]
// Port-level assertions for the cooler stability sequencer, with bind.
`timescale 1ns / 1ps

module css_checker #(
   parameter int TEMP_BITS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_accepted,
   input logic [2:0]                  rsp_cooler_state,
   input logic                        rsp_cooler_enabled,
   input logic                        rsp_monitor_active,
   input logic signed [TEMP_BITS-1:0] rsp_current_temp,
   input logic signed [TEMP_BITS:0]   rsp_temp_delta,
   input logic [1:0]                  rsp_stability_event
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted) &&
         $stable(rsp_cooler_state) && $stable(rsp_cooler_enabled) &&
         $stable(rsp_monitor_active) && $stable(rsp_current_temp) &&
         $stable(rsp_temp_delta) && $stable(rsp_stability_event))
      else $error("css: stalled result changed");

   // every accepted request yields a result the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("css: request transfer produced no result");

   // transient phases never show in a result
   a_no_transient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cooler_state != 3'(css_pkg::PH_STARTING) &&
                    rsp_cooler_state != 3'(css_pkg::PH_STOPPING))
      else $error("css: transient phase reported");

   // stability events come only from monitored ticks
   a_event_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stability_event != 2'(css_pkg::EV_NONE) |->
         rsp_accepted && rsp_monitor_active)
      else $error("css: stability event outside a monitored tick");

   // off means the monitor is stopped
   a_off_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cooler_state == 3'(css_pkg::PH_OFF) |-> !rsp_monitor_active)
      else $error("css: monitor running while off");

endmodule

bind cooler_stability_sequencer css_checker #(
   .TEMP_BITS (TEMP_BITS)
) u_css_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_accepted        (rsp_accepted),
   .rsp_cooler_state    (rsp_cooler_state),
   .rsp_cooler_enabled  (rsp_cooler_enabled),
   .rsp_monitor_active  (rsp_monitor_active),
   .rsp_current_temp    (rsp_current_temp),
   .rsp_temp_delta      (rsp_temp_delta),
   .rsp_stability_event (rsp_stability_event)
);

[tb/cooler_stability_sequencer_tb.sv]
// Self-checking testbench for the cooler stability sequencer.
`timescale 1ns / 1ps

module cooler_stability_sequencer_tb;

   localparam int TEMP_W       = 16;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;   // settle counter saturation
   localparam int CLK_HALF     = 4;                // 8 ns clock
   localparam int RESET_CYCLES = 5;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 310;
   localparam int CYCLE_LIMIT  = 400000;

   // One request transfer as the sender presents it
   typedef struct {
      css_pkg::mode_type         mode;
      logic signed [TEMP_W-1:0]  sample;
      logic signed [TEMP_W-1:0]  target;
      logic                      link;
      logic                      en_ack;
      logic                      tg_ack;
   } command_type;

   // One result transfer: outcome, drive state, temperature and event
   typedef struct {
      logic                      accepted;
      css_pkg::phase_type        state;
      logic                      cooler_en;
      logic                      monitor;
      logic signed [TEMP_W-1:0]  temp;
      logic signed [TEMP_W:0]    delta;
      css_pkg::event_type        ev;
   } status_type;

   // Shadow of the sequencer: CSRs, control state and the results still owed.
   class cooler_scoreboard;
      logic [css_pkg::TOL_BITS-1:0]    tol;
      logic [css_pkg::SETTLE_BITS-1:0] settle;
      logic                            prot;
      logic signed [TEMP_W-1:0]        hi_limit;
      logic signed [TEMP_W-1:0]        lo_limit;
      css_pkg::phase_type              phase;
      logic signed [TEMP_W-1:0]        target;
      logic signed [TEMP_W-1:0]        last;
      logic [15:0]                     settle_cnt;
      logic                            cooler_on;
      logic                            monitor_on;
      status_type                      due_status[$];
      int                              errors;

      function new();
         tol        = css_pkg::TOL_RESET;
         settle     = css_pkg::SETTLE_RESET;
         prot       = 1'b1;
         hi_limit   = 16'(css_pkg::CEIL_RESET);
         lo_limit   = 16'(css_pkg::FLOOR_RESET);
         phase      = css_pkg::PH_OFF;
         target     = '0;
         last       = '0;
         settle_cnt = '0;
         cooler_on  = 1'b0;
         monitor_on = 1'b0;
         errors     = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR %0t: %s", $time, msg);
      endtask

      // Only the low bits of each write land; unknown indexes are dropped
      function void write_reg(logic [css_pkg::CSR_IDX_BITS-1:0] idx,
                              logic [css_pkg::CSR_DATA_BITS-1:0] d);
         case (idx)
            css_pkg::CSR_TOLERANCE:    tol      = d[css_pkg::TOL_BITS-1:0];
            css_pkg::CSR_SETTLE_TICKS: settle   = d[css_pkg::SETTLE_BITS-1:0];
            css_pkg::CSR_PROTECT_EN:   prot     = d[0];
            css_pkg::CSR_TEMP_CEILING: hi_limit = d[TEMP_W-1:0];
            css_pkg::CSR_TEMP_FLOOR:   lo_limit = d[TEMP_W-1:0];
            default: ;
         endcase
      endfunction

      function bit target_allowed(logic signed [TEMP_W-1:0] t);
         return !prot || (t >= lo_limit && t <= hi_limit);
      endfunction

      // Apply one accepted request to the shadow state and queue its result
      function void apply_command(command_type c);
         status_type s;
         int      cur;
         int      dev;
         s.accepted = 1'b1;
         s.ev       = css_pkg::EV_NONE;
         case (c.mode)
            css_pkg::MODE_TICK: begin
               if (monitor_on) begin
                  if (c.link)
                     last = c.sample;
                  cur = last;
                  dev = cur - int'(target);
                  if (dev < 0)
                     dev = -dev;
                  if (phase == css_pkg::PH_COOLING || phase == css_pkg::PH_STABILIZING ||
                      phase == css_pkg::PH_STABLE) begin
                     if (dev <= int'(tol)) begin
                        if (phase == css_pkg::PH_COOLING) begin
                           phase      = css_pkg::PH_STABILIZING;
                           settle_cnt = '0;
                        end else if (phase == css_pkg::PH_STABILIZING) begin
                           if (settle_cnt != COUNT_MAX)
                              settle_cnt++;
                           if (settle_cnt >= settle) begin
                              phase = css_pkg::PH_STABLE;
                              s.ev  = css_pkg::EV_STABLE;
                           end
                        end
                     end else if (phase != css_pkg::PH_COOLING) begin
                        phase = css_pkg::PH_COOLING;
                        s.ev  = css_pkg::EV_LEFT;
                     end
                  end
                  if (prot && (cur > hi_limit || cur < lo_limit)) begin
                     phase     = css_pkg::PH_ERROR;
                     cooler_on = 1'b0;
                  end
               end
            end
            css_pkg::MODE_START: begin
               if (!c.link || !target_allowed(c.target)) begin
                  s.accepted = 1'b0;
               end else begin
                  if (phase != css_pkg::PH_OFF) begin
                     monitor_on = 1'b0;
                     cooler_on  = 1'b0;
                  end
                  target = c.target;
                  if (!c.en_ack) begin
                     phase      = css_pkg::PH_ERROR;
                     s.accepted = 1'b0;
                  end else begin
                     cooler_on = 1'b1;
                     if (!c.tg_ack) begin
                        phase      = css_pkg::PH_ERROR;
                        s.accepted = 1'b0;
                     end else begin
                        phase      = css_pkg::PH_COOLING;
                        settle_cnt = '0;
                        monitor_on = 1'b1;
                     end
                  end
               end
            end
            css_pkg::MODE_STOP: begin
               if (phase != css_pkg::PH_OFF) begin
                  monitor_on = 1'b0;
                  if (c.link)
                     cooler_on = 1'b0;
                  phase = css_pkg::PH_OFF;
               end
            end
            default: begin
               if (!target_allowed(c.target) || !c.link) begin
                  s.accepted = 1'b0;
               end else begin
                  target = c.target;
                  if (phase != css_pkg::PH_OFF && phase != css_pkg::PH_ERROR) begin
                     if (!c.tg_ack) begin
                        s.accepted = 1'b0;
                     end else begin
                        settle_cnt = '0;
                        if (phase == css_pkg::PH_STABLE)
                           phase = css_pkg::PH_COOLING;
                     end
                  end
               end
            end
         endcase
         s.state     = phase;
         s.cooler_en = cooler_on;
         s.monitor   = monitor_on;
         s.temp      = last;
         s.delta     = 17'(int'(last) - int'(target));
         due_status.insert(due_status.size(), s);
      endfunction

      task check_status(status_type got);
         status_type want;
         if (due_status.size() == 0) begin
            report("result transfer with no request outstanding");
            return;
         end
         want = due_status[0];
         due_status.delete(0);
         if (got.accepted !== want.accepted)
            report($sformatf("accepted got %0d want %0d", got.accepted, want.accepted));
         if (got.state !== want.state)
            report($sformatf("cooler_state got %0d want %0d", got.state, want.state));
         if (got.cooler_en !== want.cooler_en)
            report($sformatf("cooler_enabled got %0d want %0d", got.cooler_en, want.cooler_en));
         if (got.monitor !== want.monitor)
            report($sformatf("monitor_active got %0d want %0d", got.monitor, want.monitor));
         if (got.temp !== want.temp)
            report($sformatf("current_temp got %0d want %0d", got.temp, want.temp));
         if (got.delta !== want.delta)
            report($sformatf("temp_delta got %0d want %0d", got.delta, want.delta));
         if (got.ev !== want.ev)
            report($sformatf("stability_event got %0d want %0d", got.ev, want.ev));
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [1:0]                           req_mode = css_pkg::MODE_TICK;
   logic signed [TEMP_W-1:0]             req_sample_temp = '0;
   logic signed [TEMP_W-1:0]             req_new_target = '0;
   logic                                 req_connected = 1'b0;
   logic                                 req_enable_ack = 1'b0;
   logic                                 req_target_ack = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_accepted;
   logic [2:0]                           rsp_cooler_state;
   logic                                 rsp_cooler_enabled;
   logic                                 rsp_monitor_active;
   logic signed [TEMP_W-1:0]             rsp_current_temp;
   logic signed [TEMP_W:0]               rsp_temp_delta;
   logic [1:0]                           rsp_stability_event;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [css_pkg::CSR_IDX_BITS-1:0]     csr_index = css_pkg::CSR_TOLERANCE;
   logic [css_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;

   cooler_stability_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_sample_temp     (req_sample_temp),
      .req_new_target      (req_new_target),
      .req_connected       (req_connected),
      .req_enable_ack      (req_enable_ack),
      .req_target_ack      (req_target_ack),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_cooler_state    (rsp_cooler_state),
      .rsp_cooler_enabled  (rsp_cooler_enabled),
      .rsp_monitor_active  (rsp_monitor_active),
      .rsp_current_temp    (rsp_current_temp),
      .rsp_temp_delta      (rsp_temp_delta),
      .rsp_stability_event (rsp_stability_event),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   cooler_scoreboard sb = new();

   // Idle pressure of the current phase, in percent of cycles
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int cycles = 0;

   // Random session tracking: items left in the current start..stop session
   // and the target it is steering toward.
   int                        sess_left = 0;
   logic signed [TEMP_W-1:0]  sess_target = '0;

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Hard stop in case a handshake hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** cooler_stability_sequencer: FAILED **");
         $finish;
      end
   end

   function automatic bit pct(int n);
      return $urandom_range(99) < n;
   endfunction

   function automatic logic signed [TEMP_W-1:0] clamp_temp(int v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return 16'(v);
   endfunction

   function automatic command_type cmd(css_pkg::mode_type m, int smp, int tgt, bit lk, bit en,
                                       bit tg);
      command_type c;
      c.mode   = m;
      c.sample = 16'(smp);
      c.target = 16'(tgt);
      c.link   = lk;
      c.en_ack = en;
      c.tg_ack = tg;
      return c;
   endfunction

   // Target for start / set target: mostly inside the protection window with
   // the window edges weighted up, otherwise anything.
   function automatic logic signed [TEMP_W-1:0] pick_target();
      int span;
      if (sb.prot && sb.lo_limit <= sb.hi_limit && pct(95)) begin
         if (pct(10))
            return sb.lo_limit;
         if (pct(10))
            return sb.hi_limit;
         span = int'(sb.hi_limit) - int'(sb.lo_limit);
         return 16'(int'(sb.lo_limit) + int'($urandom_range(span)));
      end
      return 16'($urandom);
   endfunction

   // Mostly well-formed sessions (start, ticks near target with the odd set
   // target or drift, then stop) so the stable and drift paths get exercised;
   // the rest is raw noise on every field.
   function automatic command_type next_random_command();
      command_type c;
      int       r;
      int       off;
      int       cap;
      c = cmd(css_pkg::mode_type'($urandom_range(3)), int'($urandom), int'($urandom),
              $urandom_range(1), $urandom_range(1), $urandom_range(1));
      r = $urandom_range(99);
      if (r < 12)
         return c;
      if (sess_left == 0) begin
         cap         = (sb.settle > 68) ? 80 : int'(sb.settle) + 12;
         c.mode      = css_pkg::MODE_START;
         c.target    = pick_target();
         c.link      = pct(95);
         c.en_ack    = pct(93);
         c.tg_ack    = pct(93);
         sess_target = c.target;
         sess_left   = $urandom_range(cap, 3);
      end else begin
         sess_left--;
         if (sess_left == 0) begin
            c.mode = css_pkg::MODE_STOP;
            c.link = pct(90);
         end else if (r < 16) begin
            c.mode      = css_pkg::MODE_SET;
            c.target    = pick_target();
            c.link      = pct(95);
            c.tg_ack    = pct(85);
            sess_target = c.target;
         end else begin
            c.mode = css_pkg::MODE_TICK;
            c.link = pct(92);
            if (r < 20)
               off = int'(sb.tol) + 1 + int'($urandom_range(400));   // drift out
            else if (r < 26)
               off = int'(sb.tol);                                   // tolerance edge
            else
               off = int'($urandom_range(int'(sb.tol)));
            if ($urandom_range(1))
               off = -off;
            c.sample = clamp_temp(int'(sess_target) + off);
         end
      end
      return c;
   endfunction

   // Present one request and hold it until the transfer happens. valid is left
   // high on return; the next call or the caller decides when it drops.
   task automatic send_req(input command_type c);
      while (pct(sender_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= c.mode;
      req_sample_temp <= c.sample;
      req_new_target  <= c.target;
      req_connected   <= c.link;
      req_enable_ack  <= c.en_ack;
      req_target_ack  <= c.tg_ack;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.apply_command(c);
   endtask

   // One CSR transfer; the unused upper data bits carry random junk.
   // csr_valid stays high until the caller lowers it.
   task automatic write_csr(input logic [css_pkg::CSR_IDX_BITS-1:0] idx, input int width,
                            input logic [css_pkg::CSR_DATA_BITS-1:0] value);
      logic [css_pkg::CSR_DATA_BITS-1:0] mask;
      logic [css_pkg::CSR_DATA_BITS-1:0] data;
      mask = (width >= css_pkg::CSR_DATA_BITS) ? '1 : ((32'h1 << width) - 1);
      data = ($urandom & ~mask) | (value & mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Result side: check every completed transfer, stall per the phase
   always @(posedge clock) begin
      status_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.accepted  = rsp_accepted;
         seen.state     = css_pkg::phase_type'(rsp_cooler_state);
         seen.cooler_en = rsp_cooler_enabled;
         seen.monitor   = rsp_monitor_active;
         seen.temp      = rsp_current_temp;
         seen.delta     = rsp_temp_delta;
         seen.ev        = css_pkg::event_type'(rsp_stability_event);
         sb.check_status(seen);
      end
      rsp_stall <= pct(recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      automatic command_type directed[] = '{
         cmd(css_pkg::MODE_TICK,   500,     0, 1, 1, 1),   // monitor off: ignored
         cmd(css_pkg::MODE_STOP,     0,     0, 1, 1, 1),   // stop while already off
         cmd(css_pkg::MODE_SET,      0,  1000, 1, 1, 1),   // set target while off
         cmd(css_pkg::MODE_SET,      0,  2000, 0, 1, 1),   // link down: rejected
         cmd(css_pkg::MODE_START,    0,     0, 0, 1, 1),   // link down: rejected
         cmd(css_pkg::MODE_START,    0, 12801, 1, 1, 1),   // just above ceiling
         cmd(css_pkg::MODE_START,    0,-12801, 1, 1, 1),   // just below floor
         cmd(css_pkg::MODE_START,    0,   100, 1, 0, 1),   // enable refused -> error
         cmd(css_pkg::MODE_START,    0,   100, 1, 1, 0),   // target write refused
         cmd(css_pkg::MODE_STOP,     0,     0, 0, 1, 1),   // link down keeps cooler on
         cmd(css_pkg::MODE_START,    0,     0, 1, 1, 1),   // clean start -> cooling
         cmd(css_pkg::MODE_TICK,  9999,     0, 0, 1, 1),   // link down: stale sample
         cmd(css_pkg::MODE_TICK,   128,     0, 1, 1, 1),   // exactly at tolerance
         cmd(css_pkg::MODE_TICK,   129,     0, 1, 1, 1),   // one past: left event
         cmd(css_pkg::MODE_SET,      0, 12800, 1, 1, 0),   // refused write still takes target
         cmd(css_pkg::MODE_SET,      0,-12800, 1, 1, 1),   // floor target accepted
         cmd(css_pkg::MODE_TICK,-12800,     0, 1, 1, 1),   // in tolerance -> stabilizing
         cmd(css_pkg::MODE_TICK,-32768,     0, 1, 1, 1),   // drift plus under-temp trip
         cmd(css_pkg::MODE_TICK, 32767,     0, 1, 1, 1),   // monitor keeps running
         cmd(css_pkg::MODE_SET,      0,     5, 1, 1, 1),   // set target in error
         cmd(css_pkg::MODE_START,    0,-32768, 1, 1, 1),   // most negative: rejected
         cmd(css_pkg::MODE_START,    0, 32767, 1, 1, 1),   // most positive: rejected
         cmd(css_pkg::MODE_START,    0, 12800, 1, 1, 1),   // restart at the ceiling
         cmd(css_pkg::MODE_STOP,     0,     0, 1, 1, 1)
      };
      int t_tol;
      int t_settle;
      int t_prot;
      int t_hi;
      int t_lo;
      int n_rand;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         // Idle pattern rotates: none, sender, receiver, both
         case (ph % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
         endcase

         if (ph == 0) begin
            // Reset CSR values first, with the directed cases
            foreach (directed[i])
               send_req(directed[i]);
            n_rand = PHASE_ITEMS - directed.size();
         end else begin
            // Reprogram only once every owed result has drained
            while (sb.due_status.size() != 0)
               @(posedge clock);
            repeat (2) @(posedge clock);
            case (ph)
               1: begin        // tightest tolerance, widest window
                  t_tol = 1; t_settle = 1; t_prot = 1; t_hi = 32767; t_lo = -32768;
               end
               2: begin        // loosest settings, protection off, window inverted
                  t_tol = 32767; t_settle = 65535; t_prot = 0; t_hi = -32768; t_lo = 32767;
               end
               3: begin        // narrow window so trips are frequent
                  t_tol    = $urandom_range(600, 1);
                  t_settle = $urandom_range(6, 1);
                  t_prot   = 1;
                  t_hi     = $urandom_range(6000, 2000);
                  t_lo     = -int'($urandom_range(6000, 2000));
               end
               4: begin        // floor above ceiling with protection: nothing passes
                  t_tol = 200; t_settle = 3; t_prot = 1; t_hi = -100; t_lo = 100;
               end
               default: begin
                  t_tol    = pct(50) ? $urandom_range(2000, 1) : $urandom_range(32767, 1);
                  t_settle = $urandom_range(10, 1);
                  t_prot   = $urandom_range(1);
                  t_hi     = int'(16'($urandom));
                  t_lo     = int'(16'($urandom));
               end
            endcase
            write_csr(css_pkg::CSR_TOLERANCE, css_pkg::TOL_BITS, t_tol);
            write_csr(css_pkg::CSR_SETTLE_TICKS, css_pkg::SETTLE_BITS, t_settle);
            write_csr(css_pkg::CSR_PROTECT_EN, 1, t_prot);
            write_csr(css_pkg::CSR_TEMP_CEILING, TEMP_W, t_hi);
            write_csr(css_pkg::CSR_TEMP_FLOOR, TEMP_W, t_lo);
            // stray index past the map must be dropped
            write_csr(css_pkg::CSR_IDX_BITS'(css_pkg::CSR_TEMP_FLOOR + 1 + $urandom_range(2)),
                      css_pkg::CSR_DATA_BITS, $urandom);
            csr_valid <= 1'b0;
            @(posedge clock);
            sess_left = 0;
            n_rand    = PHASE_ITEMS;
         end

         repeat (n_rand)
            send_req(next_random_command());
         req_valid <= 1'b0;
      end

      // Drain, then let the result register settle before the verdict
      recv_stall_pct = 0;
      while (sb.due_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (sb.errors == 0)
         $display("** cooler_stability_sequencer: PASSED **");
      else
         $display("** cooler_stability_sequencer: FAILED **");
      $finish;
   end

endmodule

[files.f]
hdl/css_pkg.sv
hdl/css_step.sv
hdl/cooler_stability_sequencer.sv
hdl/css_checker.sv
tb/cooler_stability_sequencer_tb.sv
